### rtl/circle_pair_overlap_separation_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef CIRCLE_PAIR_OVERLAP_SEPARATION_ASSERT_SVH
`define CIRCLE_PAIR_OVERLAP_SEPARATION_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define CPOS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpos: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define CPOS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpos: next-cycle check failed");

`endif

### rtl/cpos_pkg.sv
`timescale 1ns / 1ps

package cpos_pkg;

  // Fixed-point layout of positions.
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_W         = 32;
  localparam int RAD_W         = 16;
  localparam int IM_W          = 24;
  localparam int ID_W          = 32;
  localparam int GAIN_W        = 17;
  localparam int EPS_W         = 16;
  localparam int CFG_W         = 17;
  localparam int CFG_IDX_W     = 2;

  // Derived datapath widths.
  localparam int RSUM_W  = POS_FRAC_BITS + 1;
  localparam int D2_W    = 2 * RSUM_W + 1;
  localparam int SQRT_W  = (D2_W + 1) / 2;
  localparam int SQ_TW   = 2 * SQRT_W;
  localparam int SHARE_W = POS_FRAC_BITS;
  localparam int PROD_W  = RSUM_W + GAIN_W;
  localparam int NUMA_W  = SHARE_W + IM_W;
  localparam int TOT_W   = IM_W + 1;
  localparam int NUMS_W  = RSUM_W + SHARE_W + 1;
  localparam int DIRP_W  = SHARE_W + 16;
  localparam int UP_SH   = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
  localparam int DN_SH   = (POS_FRAC_BITS >= 16) ? 0 : 16 - POS_FRAC_BITS;

  // Square root of one half in Q0.16.
  localparam logic [15:0] DIAG_Q16 = 16'd46341;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_PUSH  = 2'd0,
    REG_BIAS_GAIN = 2'd1,
    REG_NEAR_EPS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_SEPARATED = 2'd1,
    ST_FALLBACK  = 2'd2,
    ST_PINNED    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MAG_ZERO,
    MAG_DIAG,
    MAG_ONE
  } dir_mag_e;

  typedef struct packed {
    logic     neg;
    dir_mag_e mag;
  } dir_comp_t;

  // One incoming pair.
  typedef struct packed {
    logic [POS_W-1:0] a_pos_x;
    logic [POS_W-1:0] a_pos_y;
    logic [POS_W-1:0] b_pos_x;
    logic [POS_W-1:0] b_pos_y;
    logic [RAD_W-1:0] a_radius;
    logic [RAD_W-1:0] b_radius;
    logic [IM_W-1:0]  a_inv_mass;
    logic [IM_W-1:0]  b_inv_mass;
    logic [ID_W-1:0]  a_ident;
    logic [ID_W-1:0]  b_ident;
  } in_item_t;

  // Classification carried along the front pipeline.
  typedef struct packed {
    logic [POS_W-1:0]  ax;
    logic [POS_W-1:0]  ay;
    logic [POS_W-1:0]  bx;
    logic [POS_W-1:0]  by;
    logic [RSUM_W-1:0] adx;
    logic [RSUM_W-1:0] ady;
    logic              negx;
    logic              negy;
    logic [RSUM_W-1:0] rsum;
    logic              near;
    logic              ovl;
    logic              pinned;
    logic [RSUM_W-1:0] cdist;
    logic [IM_W-1:0]   ima;
    logic [IM_W-1:0]   imb;
    logic [2:0]        dir;
  } fr_t;

  // Queue entry between the front and the back.
  typedef struct packed {
    fr_t                info;
    logic [SHARE_W-1:0] sa;
    logic [SHARE_W-1:0] sb;
  } q_item_t;

  // One result.
  typedef struct packed {
    logic [POS_W-1:0] new_a_x;
    logic [POS_W-1:0] new_a_y;
    logic [POS_W-1:0] new_b_x;
    logic [POS_W-1:0] new_b_y;
    status_e          status;
  } out_item_t;

  // Converts a Q0.16 length into position units.
  function automatic logic [SHARE_W-1:0] q16_to_pos(input logic [15:0] v);
    return SHARE_W'((32'(v) << UP_SH) >> DN_SH);
  endfunction

  // X component of fallback direction k, at k*45 degrees from +x.
  function automatic dir_comp_t dir_x(input logic [2:0] k);
    dir_comp_t c;
    case (k)
      3'd0:    c = '{neg: 1'b0, mag: MAG_ONE};
      3'd1:    c = '{neg: 1'b0, mag: MAG_DIAG};
      3'd2:    c = '{neg: 1'b0, mag: MAG_ZERO};
      3'd3:    c = '{neg: 1'b1, mag: MAG_DIAG};
      3'd4:    c = '{neg: 1'b1, mag: MAG_ONE};
      3'd5:    c = '{neg: 1'b1, mag: MAG_DIAG};
      3'd6:    c = '{neg: 1'b0, mag: MAG_ZERO};
      default: c = '{neg: 1'b0, mag: MAG_DIAG};
    endcase
    return c;
  endfunction

  // Y component of fallback direction k.
  function automatic dir_comp_t dir_y(input logic [2:0] k);
    dir_comp_t c;
    case (k)
      3'd0:    c = '{neg: 1'b0, mag: MAG_ZERO};
      3'd1:    c = '{neg: 1'b0, mag: MAG_DIAG};
      3'd2:    c = '{neg: 1'b0, mag: MAG_ONE};
      3'd3:    c = '{neg: 1'b0, mag: MAG_DIAG};
      3'd4:    c = '{neg: 1'b0, mag: MAG_ZERO};
      3'd5:    c = '{neg: 1'b1, mag: MAG_DIAG};
      3'd6:    c = '{neg: 1'b1, mag: MAG_ONE};
      default: c = '{neg: 1'b1, mag: MAG_DIAG};
    endcase
    return c;
  endfunction

endpackage

### rtl/cpos_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage.
// The quotient must fit in QUO_W bits.
module cpos_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 25,
  parameter int QUO_W = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [CW-1:0]    rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int BitPos = QUO_W - 1 - s;

    logic [CW-1:0]    rem_in;
    logic [CW-1:0]    trial;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;

    if (s == 0) begin : g_first
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = CW'(den_in) << BitPos;

    // Subtract the shifted divisor when it fits and set this quotient bit.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        if (rem_in >= trial) begin
          rem_q[s] <= rem_in - trial;
          quo_q[s] <= quo_in | (QUO_W'(1) << BitPos);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

### rtl/cpos_queue.sv
`timescale 1ns / 1ps

// Small queue that decouples the front pipeline from the back pipeline.
module cpos_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cpos_pkg::q_item_t item_i,
  input  logic              pop_i,
  output logic              ready_o,
  output logic              valid_o,
  output cpos_pkg::q_item_t item_o
);
  import cpos_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full;
  logic             do_pop;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign ready_o = !full || do_pop;
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/cpos_front.sv
`timescale 1ns / 1ps

// Front pipeline: distance test, square root, push and inverse-mass shares.
// The whole pipeline advances when the queue can take its last stage.
module cpos_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  cpos_pkg::in_item_t           in_item_i,
  output logic                         in_stall_o,
  input  logic [15:0]                  max_push_i,
  input  logic [cpos_pkg::GAIN_W-1:0]  bias_gain_i,
  input  logic                         q_ready_i,
  output logic                         q_push_o,
  output cpos_pkg::q_item_t            q_item_o
);
  import cpos_pkg::*;

  logic en;

  assign en         = q_ready_i;
  assign in_stall_o = !en;

  // Stage 0: axis differences, radius sum, coarse near test.
  logic signed [POS_W:0] dx_w, dy_w;
  logic [POS_W:0]        magx_w, magy_w;
  logic [RSUM_W-1:0]     rsum_w;
  fr_t                   f0_d, f0_q;
  logic                  v0_q;

  always_comb begin
    dx_w   = (POS_W+1)'($signed(in_item_i.b_pos_x)) - (POS_W+1)'($signed(in_item_i.a_pos_x));
    dy_w   = (POS_W+1)'($signed(in_item_i.b_pos_y)) - (POS_W+1)'($signed(in_item_i.a_pos_y));
    magx_w = dx_w[POS_W] ? (POS_W+1)'(-dx_w) : (POS_W+1)'(dx_w);
    magy_w = dy_w[POS_W] ? (POS_W+1)'(-dy_w) : (POS_W+1)'(dy_w);
    rsum_w = RSUM_W'(q16_to_pos(in_item_i.a_radius)) +
             RSUM_W'(q16_to_pos(in_item_i.b_radius));
    f0_d        = '0;
    f0_d.ax     = in_item_i.a_pos_x;
    f0_d.ay     = in_item_i.a_pos_y;
    f0_d.bx     = in_item_i.b_pos_x;
    f0_d.by     = in_item_i.b_pos_y;
    f0_d.adx    = magx_w[RSUM_W-1:0];
    f0_d.ady    = magy_w[RSUM_W-1:0];
    f0_d.negx   = dx_w[POS_W];
    f0_d.negy   = dy_w[POS_W];
    f0_d.rsum   = rsum_w;
    f0_d.near   = (magx_w < (POS_W+1)'(rsum_w)) && (magy_w < (POS_W+1)'(rsum_w));
    f0_d.pinned = (in_item_i.a_inv_mass == '0) && (in_item_i.b_inv_mass == '0);
    f0_d.ima    = in_item_i.a_inv_mass;
    f0_d.imb    = in_item_i.b_inv_mass;
    f0_d.dir    = 3'((in_item_i.a_ident[2:0] << 1) + in_item_i.a_ident[2:0] +
                     in_item_i.b_ident[2:0]);
  end

  // Stage 1: squares. Stage 2: squared distance and exact overlap test.
  fr_t                 f1_q, f2_d, f2_q;
  logic                v1_q, v2_q;
  logic [2*RSUM_W-1:0] sqa_q, sqb_q, rsq_q;
  logic [D2_W-1:0]     d2_q;

  always_comb begin
    f2_d     = f1_q;
    f2_d.ovl = f1_q.near && ((D2_W'(sqa_q) + D2_W'(sqb_q)) < D2_W'(rsq_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_q  <= f0_d;
      f1_q  <= f0_q;
      sqa_q <= (2*RSUM_W)'(f0_q.adx) * (2*RSUM_W)'(f0_q.adx);
      sqb_q <= (2*RSUM_W)'(f0_q.ady) * (2*RSUM_W)'(f0_q.ady);
      rsq_q <= (2*RSUM_W)'(f0_q.rsum) * (2*RSUM_W)'(f0_q.rsum);
      f2_q  <= f2_d;
      d2_q  <= D2_W'(sqa_q) + D2_W'(sqb_q);
    end
  end

  // Pipelined integer square root, one root bit per stage.
  logic              sv_q    [SQRT_W];
  fr_t               sf_q    [SQRT_W];
  logic [SQ_TW-1:0]  srem_q  [SQRT_W];
  logic [SQRT_W-1:0] sroot_q [SQRT_W];

  for (genvar s = 0; s < SQRT_W; s++) begin : g_sqrt
    localparam int BitPos = SQRT_W - 1 - s;

    logic              v_in;
    fr_t               f_in;
    logic [SQ_TW-1:0]  rem_in;
    logic [SQ_TW-1:0]  trial;
    logic [SQRT_W-1:0] root_in;

    if (s == 0) begin : g_first
      assign v_in    = v2_q;
      assign f_in    = f2_q;
      assign rem_in  = SQ_TW'(d2_q);
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sv_q[s-1];
      assign f_in    = sf_q[s-1];
      assign rem_in  = srem_q[s-1];
      assign root_in = sroot_q[s-1];
    end

    assign trial = (SQ_TW'(root_in) << (BitPos + 1)) + (SQ_TW'(1) << (2 * BitPos));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[s] <= 1'b0;
      end else if (en) begin
        sv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sf_q[s] <= f_in;
        if (rem_in >= trial) begin
          srem_q[s]  <= rem_in - trial;
          sroot_q[s] <= root_in | (SQRT_W'(1) << BitPos);
        end else begin
          srem_q[s]  <= rem_in;
          sroot_q[s] <= root_in;
        end
      end
    end
  end

  // Stage 3: overlap times gain. Stage 4: clamp. Stage 5: share numerators.
  fr_t                f3_d, f3_q, f4_q, f5_q;
  logic               v3_q, v4_q, v5_q;
  logic [RSUM_W-1:0]  dist_w;
  logic [PROD_W-1:0]  prod3_q;
  logic [SHARE_W-1:0] push4_q, limit_w;
  logic [PROD_W-17:0] push_raw_w;
  logic [NUMA_W-1:0]  na5_q, nb5_q;
  logic [TOT_W-1:0]   tot5_q;

  assign dist_w     = sroot_q[SQRT_W-1][RSUM_W-1:0];
  assign limit_w    = q16_to_pos(max_push_i);
  assign push_raw_w = prod3_q[PROD_W-1:16];

  always_comb begin
    f3_d       = sf_q[SQRT_W-1];
    f3_d.cdist = dist_w;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f3_q      <= f3_d;
      prod3_q   <= PROD_W'(sf_q[SQRT_W-1].rsum - dist_w) * PROD_W'(bias_gain_i);
      f4_q      <= f3_q;
      push4_q   <= (push_raw_w > (PROD_W-16)'(limit_w)) ? limit_w
                                                       : push_raw_w[SHARE_W-1:0];
      f5_q      <= f4_q;
      na5_q     <= NUMA_W'(push4_q) * NUMA_W'(f4_q.ima);
      nb5_q     <= NUMA_W'(push4_q) * NUMA_W'(f4_q.imb);
      tot5_q    <= TOT_W'(f4_q.ima) + TOT_W'(f4_q.imb);
    end
  end

  // Share dividers and their side pipeline.
  logic [SHARE_W-1:0] sa_w, sb_w;
  logic               dv_q [SHARE_W];
  fr_t                df_q [SHARE_W];

  cpos_div #(.NUM_W(NUMA_W), .DEN_W(TOT_W), .QUO_W(SHARE_W)) u_div_a (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (na5_q),
    .den_i (tot5_q),
    .quo_o (sa_w)
  );

  cpos_div #(.NUM_W(NUMA_W), .DEN_W(TOT_W), .QUO_W(SHARE_W)) u_div_b (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nb5_q),
    .den_i (tot5_q),
    .quo_o (sb_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      df_q[0] <= f5_q;
      for (int s = 1; s < SHARE_W; s++) begin
        df_q[s] <= df_q[s-1];
      end
    end
  end

  // Valid bits of the fixed stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      for (int s = 0; s < SHARE_W; s++) begin
        dv_q[s] <= 1'b0;
      end
    end else if (en) begin
      v0_q    <= in_valid_i;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      v3_q    <= sv_q[SQRT_W-1];
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      dv_q[0] <= v5_q;
      for (int s = 1; s < SHARE_W; s++) begin
        dv_q[s] <= dv_q[s-1];
      end
    end
  end

  assign q_push_o      = en && dv_q[SHARE_W-1];
  assign q_item_o.info = df_q[SHARE_W-1];
  assign q_item_o.sa   = sa_w;
  assign q_item_o.sb   = sb_w;

endmodule

### rtl/cpos_back.sv
`timescale 1ns / 1ps

// Back pipeline: displacement along the normal or the fallback direction,
// saturating position update and the output register.
module cpos_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  cpos_pkg::q_item_t            q_item_i,
  output logic                         q_pop_o,
  input  logic [cpos_pkg::EPS_W-1:0]   near_eps_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cpos_pkg::out_item_t          out_item_o
);
  import cpos_pkg::*;

  // Magnitude of one fallback component applied to a share.
  function automatic logic [SHARE_W-1:0] dir_mag(input dir_mag_e m,
                                                 input logic [SHARE_W-1:0] share,
                                                 input logic [DIRP_W-1:0] dp);
    logic [DIRP_W:0] rounded;
    rounded = (DIRP_W+1)'(dp) + (DIRP_W+1)'(HALF_Q16);
    case (m)
      MAG_ONE:  return share;
      MAG_DIAG: return SHARE_W'(rounded >> 16);
      default:  return '0;
    endcase
  endfunction

  // Applies a signed displacement and saturates to the 32-bit range.
  function automatic logic [POS_W-1:0] move(input logic [POS_W-1:0] pos,
                                            input logic [SHARE_W-1:0] mag,
                                            input logic neg,
                                            input logic sub);
    logic signed [POS_W+1:0] p;
    logic signed [POS_W+1:0] d;
    logic signed [POS_W+1:0] r;
    p = (POS_W+2)'($signed(pos));
    d = $signed((POS_W+2)'(mag));
    r = (neg ^ sub) ? p - d : p + d;
    if (r > (POS_W+2)'($signed({1'b0, {(POS_W-1){1'b1}}}))) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end else if (r < (POS_W+2)'($signed({1'b1, {(POS_W-1){1'b0}}}))) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end
    return r[POS_W-1:0];
  endfunction

  logic en;

  assign en      = !(out_valid_o && out_stall_i);
  assign q_pop_o = en && q_valid_i;

  // Stage 0: numerators of the normal scaling and fallback products.
  logic               bv0_q;
  q_item_t            bi0_q;
  logic [NUMS_W-1:0]  nxa_q, nya_q, nxb_q, nyb_q;
  logic [DIRP_W-1:0]  dpa_q, dpb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bi0_q <= q_item_i;
      nxa_q <= NUMS_W'(q_item_i.info.adx) * NUMS_W'(q_item_i.sa) +
               NUMS_W'(q_item_i.info.cdist >> 1);
      nya_q <= NUMS_W'(q_item_i.info.ady) * NUMS_W'(q_item_i.sa) +
               NUMS_W'(q_item_i.info.cdist >> 1);
      nxb_q <= NUMS_W'(q_item_i.info.adx) * NUMS_W'(q_item_i.sb) +
               NUMS_W'(q_item_i.info.cdist >> 1);
      nyb_q <= NUMS_W'(q_item_i.info.ady) * NUMS_W'(q_item_i.sb) +
               NUMS_W'(q_item_i.info.cdist >> 1);
      dpa_q <= DIRP_W'(q_item_i.sa) * DIRP_W'(DIAG_Q16);
      dpb_q <= DIRP_W'(q_item_i.sb) * DIRP_W'(DIAG_Q16);
    end
  end

  // Four dividers by the centre distance.
  logic [SHARE_W-1:0] qxa_w, qya_w, qxb_w, qyb_w;

  cpos_div #(.NUM_W(NUMS_W), .DEN_W(RSUM_W), .QUO_W(SHARE_W)) u_div_xa (
    .clk_i (clk_i), .en_i (en), .num_i (nxa_q), .den_i (bi0_q.info.cdist), .quo_o (qxa_w)
  );
  cpos_div #(.NUM_W(NUMS_W), .DEN_W(RSUM_W), .QUO_W(SHARE_W)) u_div_ya (
    .clk_i (clk_i), .en_i (en), .num_i (nya_q), .den_i (bi0_q.info.cdist), .quo_o (qya_w)
  );
  cpos_div #(.NUM_W(NUMS_W), .DEN_W(RSUM_W), .QUO_W(SHARE_W)) u_div_xb (
    .clk_i (clk_i), .en_i (en), .num_i (nxb_q), .den_i (bi0_q.info.cdist), .quo_o (qxb_w)
  );
  cpos_div #(.NUM_W(NUMS_W), .DEN_W(RSUM_W), .QUO_W(SHARE_W)) u_div_yb (
    .clk_i (clk_i), .en_i (en), .num_i (nyb_q), .den_i (bi0_q.info.cdist), .quo_o (qyb_w)
  );

  // Side pipeline matching the divider latency.
  logic              bv_q   [SHARE_W];
  q_item_t           bi_q   [SHARE_W];
  logic [DIRP_W-1:0] bdpa_q [SHARE_W];
  logic [DIRP_W-1:0] bdpb_q [SHARE_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      bi_q[0]   <= bi0_q;
      bdpa_q[0] <= dpa_q;
      bdpb_q[0] <= dpb_q;
      for (int s = 1; s < SHARE_W; s++) begin
        bi_q[s]   <= bi_q[s-1];
        bdpa_q[s] <= bdpa_q[s-1];
        bdpb_q[s] <= bdpb_q[s-1];
      end
    end
  end

  // Final selection of displacements and status.
  q_item_t            it;
  dir_comp_t          cx, cy;
  logic               fallback;
  status_e            status_w;
  logic [SHARE_W-1:0] mxa, mya, mxb, myb;
  logic               nx, ny;
  out_item_t          out_d, out_q;
  logic               out_valid_q;

  always_comb begin
    it       = bi_q[SHARE_W-1];
    cx       = dir_x(it.info.dir);
    cy       = dir_y(it.info.dir);
    fallback = (32'(it.info.cdist) <= 32'(near_eps_i));
    if (!it.info.ovl) begin
      status_w = ST_NONE;
    end else if (it.info.pinned) begin
      status_w = ST_PINNED;
    end else if (fallback) begin
      status_w = ST_FALLBACK;
    end else begin
      status_w = ST_SEPARATED;
    end
    mxa = '0;
    mya = '0;
    mxb = '0;
    myb = '0;
    nx  = 1'b0;
    ny  = 1'b0;
    case (status_w)
      ST_SEPARATED: begin
        mxa = qxa_w;
        mya = qya_w;
        mxb = qxb_w;
        myb = qyb_w;
        nx  = it.info.negx;
        ny  = it.info.negy;
      end
      ST_FALLBACK: begin
        mxa = dir_mag(cx.mag, it.sa, bdpa_q[SHARE_W-1]);
        mya = dir_mag(cy.mag, it.sa, bdpa_q[SHARE_W-1]);
        mxb = dir_mag(cx.mag, it.sb, bdpb_q[SHARE_W-1]);
        myb = dir_mag(cy.mag, it.sb, bdpb_q[SHARE_W-1]);
        nx  = cx.neg;
        ny  = cy.neg;
      end
      default: begin
      end
    endcase
    out_d.new_a_x = move(it.info.ax, mxa, nx, 1'b1);
    out_d.new_a_y = move(it.info.ay, mya, ny, 1'b1);
    out_d.new_b_x = move(it.info.bx, mxb, nx, 1'b0);
    out_d.new_b_y = move(it.info.by, myb, ny, 1'b0);
    out_d.status  = status_w;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Valid bits of the back pipeline and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv0_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < SHARE_W; s++) begin
        bv_q[s] <= 1'b0;
      end
    end else if (en) begin
      bv0_q       <= q_valid_i;
      bv_q[0]     <= bv0_q;
      out_valid_q <= bv_q[SHARE_W-1];
      for (int s = 1; s < SHARE_W; s++) begin
        bv_q[s] <= bv_q[s-1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/circle_pair_overlap_separation.sv
`timescale 1ns / 1ps

// Position correction for one pair of overlapping circular agents.
// Input channel: in_valid_i / in_stall_o with one pair per transaction
// (positions, radii, inverse masses, ids). Output channel: out_valid_o /
// out_stall_i with both corrected positions and pair_status_o per transaction.
// A transaction completes at a rising edge with valid high and stall low.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 max_push, 1 bias_gain, 2 near_eps); other indexes are ignored.
// Throughput: one pair per cycle while the receiver does not stall. The depth
// of the pipeline is set by the 18-stage square root and the two 16-stage
// divider chains (shares, then per-axis scaling by the distance).
// A front pipeline feeds a QUEUE_DEPTH-entry queue that feeds a back pipeline
// ending in the output register. When the receiver stalls, the back pipeline
// holds, the queue fills, then the front holds and in_stall_o rises.
// Reset clears all valid bits and the queue and loads the register defaults;
// the block takes a transaction in the first cycle after reset.
module circle_pair_overlap_separation #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpos_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpos_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            a_pos_x_i,
  input  logic signed [31:0]            a_pos_y_i,
  input  logic signed [31:0]            b_pos_x_i,
  input  logic signed [31:0]            b_pos_y_i,
  input  logic [15:0]                   a_radius_i,
  input  logic [15:0]                   b_radius_i,
  input  logic [23:0]                   a_inv_mass_i,
  input  logic [23:0]                   b_inv_mass_i,
  input  logic [31:0]                   a_ident_i,
  input  logic [31:0]                   b_ident_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            new_a_x_o,
  output logic signed [31:0]            new_a_y_o,
  output logic signed [31:0]            new_b_x_o,
  output logic signed [31:0]            new_b_y_o,
  output logic [1:0]                    pair_status_o
);
  import cpos_pkg::*;

  // Configuration registers.
  logic [15:0]       max_push_q;
  logic [GAIN_W-1:0] bias_gain_q;
  logic [EPS_W-1:0]  near_eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_push_q  <= 16'd32768;
      bias_gain_q <= 17'd68813;
      near_eps_q  <= 16'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_PUSH:  max_push_q  <= cfg_data_i[15:0];
        REG_BIAS_GAIN: bias_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_NEAR_EPS:  near_eps_q  <= cfg_data_i[EPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input transaction packing.
  in_item_t in_item;

  assign in_item.a_pos_x    = a_pos_x_i;
  assign in_item.a_pos_y    = a_pos_y_i;
  assign in_item.b_pos_x    = b_pos_x_i;
  assign in_item.b_pos_y    = b_pos_y_i;
  assign in_item.a_radius   = a_radius_i;
  assign in_item.b_radius   = b_radius_i;
  assign in_item.a_inv_mass = a_inv_mass_i;
  assign in_item.b_inv_mass = b_inv_mass_i;
  assign in_item.a_ident    = a_ident_i;
  assign in_item.b_ident    = b_ident_i;

  logic      q_ready, q_push, q_valid, q_pop;
  q_item_t   q_wr_item, q_rd_item;
  out_item_t out_item;

  cpos_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall_o),
    .max_push_i  (max_push_q),
    .bias_gain_i (bias_gain_q),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_item_o    (q_wr_item)
  );

  cpos_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .pop_i   (q_pop),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_rd_item)
  );

  cpos_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_rd_item),
    .q_pop_o     (q_pop),
    .near_eps_i  (near_eps_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item)
  );

  // Output transaction unpacking.
  assign new_a_x_o     = out_item.new_a_x;
  assign new_a_y_o     = out_item.new_a_y;
  assign new_b_x_o     = out_item.new_b_x;
  assign new_b_y_o     = out_item.new_b_y;
  assign pair_status_o = out_item.status;

endmodule

### rtl/cpos_checker.sv
`timescale 1ns / 1ps
`include "circle_pair_overlap_separation_assert.svh"

// Port-level checks of the top level.
module cpos_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] new_a_x_o,
  input logic [31:0] new_a_y_o,
  input logic [31:0] new_b_x_o,
  input logic [31:0] new_b_y_o,
  input logic [1:0]  pair_status_o
);

  // A stalled result stays offered and unchanged.
  `CPOS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(new_a_x_o) && $stable(new_a_y_o) && $stable(new_b_x_o) && $stable(new_b_y_o) && $stable(pair_status_o))

  // The input side only stalls when the output side is blocked.
  `CPOS_ASSERT_IMPLY(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // No result is offered right after reset is released.
  `CPOS_ASSERT_IMPLY(a_reset_empty, $rose(rst_ni), !out_valid_o)

endmodule

bind circle_pair_overlap_separation cpos_checker u_cpos_checker (.*);
